// ===== sv/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbs_pkg
// Types and constants shared by the download block sequencer.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int FRAME_BYTES      = 64;
    localparam int SECTOR_BYTES     = 4096;
    localparam int CRC_BYTES        = 2;
    localparam int SLOTS_PER_SECTOR = SECTOR_BYTES / FRAME_BYTES;
    localparam int FRAME_SHIFT      = $clog2(FRAME_BYTES);
    localparam int SLOT_W           = $clog2(SLOTS_PER_SECTOR);

    localparam logic [7:0]  MIN_XFER_LEN  = 8'(3 + CRC_BYTES);
    localparam logic [7:0]  MIN_REQ_LEN   = 8'd11;
    localparam logic [7:0]  EXIT_LEN      = 8'd1;
    localparam logic [31:0] SECTOR_STEP   = 32'(SECTOR_BYTES);
    localparam logic [15:0] BLOCK_LEN_RST = 16'd64;
    localparam logic [31:0] FLASH_BASE_RST = 32'h0003_2000;

    localparam int PADDR_W = 3;
    localparam logic REG_BLOCK_LEN  = 1'b0;
    localparam logic REG_FLASH_BASE = 1'b1;

    localparam logic [1:0] OP_REQUEST  = 2'd0;
    localparam logic [1:0] OP_TRANSFER = 2'd1;
    localparam logic [1:0] OP_EXIT     = 2'd2;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_LEN   = 3'd1,
        ST_RANGE = 3'd2,
        ST_SEQ   = 3'd3,
        ST_BLOCK = 3'd4,
        ST_SUSP  = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  msg_length;
        logic [7:0]  format_byte;
        logic [7:0]  length_format;
        logic [31:0] address_bytes;
        logic [31:0] size_bytes;
        logic [15:0] block_seq;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        write_payload;
        logic [5:0]  slot_index;
        logic        program_sector;
        logic [31:0] sector_address;
        logic        transfer_complete;
    } t_rsp;

    typedef struct packed {
        logic [15:0] block_payload_len;
        logic [31:0] flash_base;
    } t_cfg;

endpackage

// ===== sv/download_block_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// download_block_sequencer_core
// Download session checker: request download, transfer data, transfer exit.
// ----------------------------------------------------------------------------
// One request item is accepted per clock while the skid stage is empty, and
// its result item is registered at the accepting edge. The session state is
// updated by a single pass of compare/add logic at the accepting edge; the
// result goes to an output register backed by a one-entry skid stage, so
// input is taken every cycle as long as the skid stage is empty and one
// stalled result is absorbed without losing throughput.
module download_block_sequencer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  dbs_pkg::t_req               i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output dbs_pkg::t_rsp               o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    dbs_pkg::t_cfg cfg;

    dbs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // session state
    logic                       r_session_open, n_session_open;
    logic                       r_awaiting_exit, n_awaiting_exit;
    logic [15:0]                r_expected_seq, n_expected_seq;
    logic [15:0]                r_block_total, n_block_total;
    logic [31:0]                r_announced_size, n_announced_size;
    logic [31:0]                r_received_len, n_received_len;
    logic [dbs_pkg::SLOT_W-1:0] r_slot_count, n_slot_count;
    logic [31:0]                r_next_sector, n_next_sector;

    // output stage
    dbs_pkg::t_rsp r_out, r_skid, n_rsp;
    logic          r_out_valid, r_skid_valid;
    logic          accept, out_free;

    // request decode
    logic [3:0]  addr_cnt, size_cnt;
    logic        addr_ok, size_ok, addr_odd;
    logic [31:0] size_val;
    logic [26:0] blocks;
    logic        frac;

    // transfer decode
    logic [7:0]  pay;
    logic        pay_bad, is_repeat, seq_lt, seq_eq;
    logic [31:0] sum;
    logic [15:0] seq;

    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_req_ready = !r_skid_valid;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    always_comb begin
        addr_cnt = i_req.length_format[7:4];
        size_cnt = i_req.length_format[3:0];
        case (addr_cnt)
            4'd1:    begin addr_ok = 1'b1; addr_odd = i_req.address_bytes[24]; end
            4'd2:    begin addr_ok = 1'b1; addr_odd = i_req.address_bytes[16]; end
            4'd4:    begin addr_ok = 1'b1; addr_odd = i_req.address_bytes[0];  end
            default: begin addr_ok = 1'b0; addr_odd = 1'b0; end
        endcase
        case (size_cnt)
            4'd1:    begin size_ok = 1'b1; size_val = {24'd0, i_req.size_bytes[31:24]}; end
            4'd2:    begin size_ok = 1'b1; size_val = {16'd0, i_req.size_bytes[31:16]}; end
            4'd4:    begin size_ok = 1'b1; size_val = i_req.size_bytes; end
            default: begin size_ok = 1'b0; size_val = 32'd0; end
        endcase
        frac   = |size_val[dbs_pkg::FRAME_SHIFT-1:0];
        blocks = 27'(size_val >> dbs_pkg::FRAME_SHIFT) + 27'(frac);
    end

    always_comb begin
        seq       = i_req.block_seq;
        pay       = i_req.msg_length - dbs_pkg::MIN_XFER_LEN;
        seq_lt    = seq < r_block_total;
        seq_eq    = seq == r_block_total;
        pay_bad   = {8'd0, pay} != cfg.block_payload_len;
        is_repeat = (r_expected_seq > 16'd1) && (seq == r_expected_seq - 16'd1);
        sum       = r_received_len + {24'd0, pay};
    end

    always_comb begin
        n_session_open   = r_session_open;
        n_awaiting_exit  = r_awaiting_exit;
        n_expected_seq   = r_expected_seq;
        n_block_total    = r_block_total;
        n_announced_size = r_announced_size;
        n_received_len   = r_received_len;
        n_slot_count     = r_slot_count;
        n_next_sector    = r_next_sector;
        n_rsp            = '0;
        n_rsp.status     = dbs_pkg::ST_OK;

        case (i_req.operation)
            dbs_pkg::OP_REQUEST: begin
                if (i_req.msg_length < dbs_pkg::MIN_REQ_LEN) begin
                    n_rsp.status = dbs_pkg::ST_LEN;
                end else if (i_req.format_byte != 8'd0 || !addr_ok || !size_ok ||
                             addr_odd || blocks > 27'd65535) begin
                    n_rsp.status = dbs_pkg::ST_RANGE;
                end else begin
                    n_session_open   = 1'b1;
                    n_awaiting_exit  = 1'b0;
                    n_expected_seq   = 16'd1;
                    n_received_len   = 32'd0;
                    n_announced_size = size_val;
                    n_block_total    = blocks[15:0];
                    n_slot_count     = '0;
                    n_next_sector    = cfg.flash_base;
                end
            end
            dbs_pkg::OP_TRANSFER: begin
                if (i_req.msg_length < dbs_pkg::MIN_XFER_LEN) begin
                    n_rsp.status = dbs_pkg::ST_LEN;
                end else if (!r_session_open) begin
                    n_rsp.status = dbs_pkg::ST_SEQ;
                end else if (is_repeat) begin
                    if ((seq_lt && pay_bad) ||
                        (seq_eq && r_received_len != r_announced_size)) begin
                        n_rsp.status = dbs_pkg::ST_LEN;
                    end else begin
                        n_rsp.write_payload = 1'b1;
                        n_rsp.slot_index    = 6'(r_slot_count - 1'b1);
                        if (r_slot_count == '0) begin
                            n_rsp.program_sector = 1'b1;
                            n_rsp.sector_address = r_next_sector - dbs_pkg::SECTOR_STEP;
                        end
                    end
                end else if (r_awaiting_exit) begin
                    n_rsp.status = dbs_pkg::ST_SEQ;
                end else if (seq != r_expected_seq) begin
                    n_rsp.status = dbs_pkg::ST_BLOCK;
                end else if (seq_lt && pay_bad) begin
                    n_rsp.status = dbs_pkg::ST_LEN;
                end else if ((seq_lt && sum >= r_announced_size) ||
                             (seq_eq && sum != r_announced_size)) begin
                    n_rsp.status = dbs_pkg::ST_SUSP;
                end else begin
                    n_received_len      = sum;
                    n_expected_seq      = r_expected_seq + 16'd1;
                    n_rsp.write_payload = 1'b1;
                    n_rsp.slot_index    = 6'(r_slot_count);
                    n_slot_count        = r_slot_count + 1'b1;
                    if (!seq_lt || r_slot_count == '1) begin
                        n_rsp.program_sector = 1'b1;
                        n_rsp.sector_address = r_next_sector;
                        n_next_sector        = r_next_sector + dbs_pkg::SECTOR_STEP;
                        n_slot_count         = '0;
                    end
                    if (sum == r_announced_size) begin
                        n_awaiting_exit = 1'b1;
                    end
                end
            end
            dbs_pkg::OP_EXIT: begin
                if (i_req.msg_length != dbs_pkg::EXIT_LEN) begin
                    n_rsp.status = dbs_pkg::ST_LEN;
                end else if (!r_awaiting_exit) begin
                    n_rsp.status = dbs_pkg::ST_SEQ;
                end else begin
                    n_session_open   = 1'b0;
                    n_awaiting_exit  = 1'b0;
                    n_expected_seq   = 16'd1;
                    n_block_total    = 16'd0;
                    n_received_len   = 32'd0;
                    n_announced_size = 32'd0;
                end
            end
            default: n_rsp.status = dbs_pkg::ST_SEQ;
        endcase

        n_rsp.transfer_complete = n_awaiting_exit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_open   <= 1'b0;
            r_awaiting_exit  <= 1'b0;
            r_expected_seq   <= 16'd1;
            r_block_total    <= 16'd0;
            r_announced_size <= 32'd0;
            r_received_len   <= 32'd0;
            r_slot_count     <= '0;
            r_next_sector    <= dbs_pkg::FLASH_BASE_RST;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_session_open   <= n_session_open;
                r_awaiting_exit  <= n_awaiting_exit;
                r_expected_seq   <= n_expected_seq;
                r_block_total    <= n_block_total;
                r_announced_size <= n_announced_size;
                r_received_len   <= n_received_len;
                r_slot_count     <= n_slot_count;
                r_next_sector    <= n_next_sector;
            end
            if (r_skid_valid) begin
                if (i_rsp_ready) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_rsp_ready) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (out_free) begin
                r_out <= n_rsp;
            end else begin
                r_skid <= n_rsp;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_exit_in_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting_exit |-> r_session_open)
        else $error("awaiting exit outside an open session");

    a_prog_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.program_sector) |-> o_rsp.write_payload)
        else $error("sector program without block write");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.write_payload) |->
            (o_rsp.slot_index == 6'd0 && o_rsp.sector_address == 32'd0))
        else $error("slot or sector address set on a rejected item");

    a_err_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != dbs_pkg::ST_OK) |-> !o_rsp.write_payload)
        else $error("block write on an error status");

endmodule

// ===== sv/dbs_apb_regs.sv =====
// ----------------------------------------------------------------------------
// dbs_apb_regs
// APB register file: block payload length and flash base address.
// ----------------------------------------------------------------------------
module dbs_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output dbs_pkg::t_cfg               o_cfg
);

    logic [15:0] r_block_len;
    logic [31:0] r_flash_base;
    logic        reg_sel;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len  <= dbs_pkg::BLOCK_LEN_RST;
            r_flash_base <= dbs_pkg::FLASH_BASE_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                dbs_pkg::REG_BLOCK_LEN:  r_block_len  <= pwdata[15:0];
                dbs_pkg::REG_FLASH_BASE: r_flash_base <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            dbs_pkg::REG_BLOCK_LEN:  prdata = {16'd0, r_block_len};
            dbs_pkg::REG_FLASH_BASE: prdata = r_flash_base;
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg.block_payload_len = r_block_len;
    assign o_cfg.flash_base        = r_flash_base;

endmodule
